FILE: rtl/core/rktg_pkg.sv
// Shared types and constants for the ramp kernel tap generator.
// Holds the register indexes, window codes, configuration struct and series coefficients.
// Depends on nothing.
package rktg_pkg;

  localparam int unsigned MAX_RADIUS = 1024;
  localparam int unsigned RAD_W      = 11;
  localparam int unsigned TAP_W      = 12;

  localparam logic [1:0] REG_RADIUS = 2'd0;
  localparam logic [1:0] REG_WINDOW = 2'd1;
  localparam logic [1:0] REG_INVSQ  = 2'd2;

  localparam logic [2:0] WIN_RAMLAK  = 3'd0;
  localparam logic [2:0] WIN_SHEPP   = 3'd1;
  localparam logic [2:0] WIN_COSINE  = 3'd2;
  localparam logic [2:0] WIN_HAMMING = 3'd3;
  localparam logic [2:0] WIN_HANN    = 3'd4;

  localparam logic [28:0] INV_PI_SQ_Q32 = 29'd435171170;
  localparam logic [16:0] Q16_ONE       = 17'd65536;
  localparam logic [16:0] HAMMING_BASE  = 17'd5243;
  localparam logic [16:0] HAMMING_GAIN  = 17'd60293;

  typedef struct packed {
    logic [RAD_W-1:0] radius;
    logic [2:0]       window;
    logic [31:0]      inv_sq;
  } cfg_t;

  // Coefficients of the alternating series, innermost first; the last one gives 1 - z*r.
  function automatic logic [16:0] series_coef(input logic sinc, input logic [2:0] idx);
    logic [16:0] c;
    c = Q16_ONE;
    case (idx)
      3'd0: c = sinc ? 17'd7     : 17'd60;
      3'd1: c = sinc ? 17'd195   : 17'd1367;
      3'd2: c = sinc ? 17'd3325  : 17'd16624;
      3'd3: c = sinc ? 17'd26951 : 17'd80852;
      default: c = Q16_ONE;
    endcase
    return c;
  endfunction

endpackage

FILE: rtl/core/rktg_cfg.sv
// Configuration register file of the ramp kernel tap generator.
// Decodes register writes and limits the radius; uses rktg_pkg.
module rktg_cfg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_valid,
  input  logic [1:0]        cfg_index,
  input  logic [31:0]       cfg_data,
  output logic              cfg_ready,
  output rktg_pkg::cfg_t    cfg
);
  import rktg_pkg::*;

  logic [RAD_W-1:0] radius_r;
  logic [2:0]       window_r;
  logic [31:0]      inv_sq_r;
  logic [RAD_W-1:0] radius_nxt;

  assign cfg_ready = 1'b1;

  always_comb begin
    radius_nxt = cfg_data[RAD_W-1:0];
    if (cfg_data[RAD_W-1:0] > RAD_W'(MAX_RADIUS)) begin
      radius_nxt = RAD_W'(MAX_RADIUS);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= RAD_W'(255);
      window_r <= WIN_RAMLAK;
      inv_sq_r <= 32'd65536;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_RADIUS: radius_r <= radius_nxt;
        REG_WINDOW: window_r <= cfg_data[2:0];
        REG_INVSQ:  inv_sq_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign cfg.radius = radius_r;
  assign cfg.window = window_r;
  assign cfg.inv_sq = inv_sq_r;

endmodule

FILE: rtl/core/ramp_kernel_tap_generator_core.sv
// Top level of the ramp kernel tap generator: a forty-stage pipeline from tap position to
// windowed Q16.16 coefficient. Uses rktg_pkg and rktg_cfg.
// A result passes stg_r[0] to stg_r[39] in order; one request per cycle while no output stalls.
// The rate is set by the stage shift: all stages advance together unless the output stalls.
// Two bit-serial dividers (one quotient bit per stage) and the multiplier stages set depth.
// Synchronous reset empties the pipeline and restores the register defaults.
module ramp_kernel_tap_generator_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [11:0]         in_tap_position,
  output logic                out_valid,
  input  logic                out_stall,
  output logic signed [31:0]  out_coefficient,
  output logic                out_position_error,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [31:0]         cfg_data
);
  import rktg_pkg::*;

  localparam int unsigned NST = 40;

  typedef struct packed {
    logic               err;
    logic               zero;
    logic               odd;
    logic [2:0]         kind;
    logic [31:0]        inv;
    logic [11:0]        a;
    logic [10:0]        rm;
    logic [23:0]        d;
    logic [60:0]        num;
    logic [27:0]        pn;
    logic [10:0]        prem;
    logic [29:0]        qn;
    logic [23:0]        qrem;
    logic [16:0]        z;
    logic signed [19:0] sr;
    logic [16:0]        cw;
    logic [16:0]        c2;
    logic [15:0]        w15;
    logic [31:0]        mag;
    logic [31:0]        coef;
  } item_t;

  cfg_t             cfg;
  item_t            stg_r [NST];
  logic [NST-1:0]   vld_r;
  logic             adv;

  function automatic item_t entry(input logic [11:0] tap, input cfg_t c);
    item_t y;
    logic [11:0] r12;
    y      = '0;
    r12    = {1'b0, c.radius};
    y.err  = {1'b0, tap} > {1'b0, c.radius, 1'b0};
    y.a    = (tap >= r12) ? (tap - r12) : (r12 - tap);
    y.zero = (y.a == 12'd0);
    y.odd  = y.a[0];
    y.rm   = (c.radius == '0) ? 11'd1 : c.radius;
    y.kind = c.window;
    y.inv  = c.inv_sq;
    return y;
  endfunction

  function automatic item_t step(input int unsigned k, input item_t x);
    item_t       y;
    logic [61:0] nsum;
    logic [24:0] qt;
    logic [11:0] pt;
    logic        qb;
    logic        pb;
    logic [16:0] p;
    logic [16:0] rc;
    logic [33:0] sp;
    logic [17:0] sh;
    logic [16:0] cc;
    logic [33:0] hp;
    logic [17:0] wsum;
    logic [17:0] wsel;
    logic [33:0] isum;
    logic [47:0] fp;
    logic [32:0] res;
    y = x;
    if (k == 1) begin
      y.d    = {12'd0, x.a} * {12'd0, x.a};
      y.num  = {29'd0, x.inv} * {32'd0, INV_PI_SQ_Q32};
      y.pn   = {x.a, 16'd0} + {17'd0, 1'b0, x.rm[10:1]};
      y.prem = '0;
    end
    if (k == 2) begin
      nsum   = {1'b0, x.num} + {7'd0, x.d, 31'd0};
      y.qn   = nsum[61:32];
      y.qrem = '0;
    end
    if (k >= 3 && k <= 32) begin
      qt = {x.qrem, x.qn[29]};
      qb = (qt >= {1'b0, x.d});
      if (qb) begin
        qt = qt - {1'b0, x.d};
      end
      y.qrem = qt[23:0];
      y.qn   = {x.qn[28:0], qb};
    end
    if (k >= 3 && k <= 30) begin
      pt = {x.prem, x.pn[27]};
      pb = (pt >= {1'b0, x.rm});
      if (pb) begin
        pt = pt - {1'b0, x.rm};
      end
      y.prem = pt[10:0];
      y.pn   = {x.pn[26:0], pb};
    end
    if (k == 31) begin
      p    = (x.pn > {11'd0, Q16_ONE}) ? Q16_ONE : x.pn[16:0];
      sp   = {17'd0, p} * {17'd0, p} + 34'd32768;
      y.z  = sp[32:16];
      y.sr = (x.kind == WIN_SHEPP) ? 20'sd0 : 20'sd2;
    end
    if (k >= 32 && k <= 36) begin
      rc   = x.sr[19] ? 17'd0 : x.sr[16:0];
      sp   = {17'd0, rc} * {17'd0, x.z} + 34'd32768;
      sh   = sp[33:16];
      y.sr = $signed({3'b000, series_coef(x.kind == WIN_SHEPP, 3'(k - 32))})
             - $signed({2'b00, sh});
    end
    if (k == 37) begin
      if (x.sr[19]) begin
        cc = 17'd0;
      end else if (x.sr > $signed({3'b000, Q16_ONE})) begin
        cc = Q16_ONE;
      end else begin
        cc = x.sr[16:0];
      end
      y.cw = cc;
      sp   = {17'd0, cc} * {17'd0, cc} + 34'd32768;
      y.c2 = sp[32:16];
    end
    if (k == 38) begin
      hp   = {17'd0, HAMMING_GAIN} * {17'd0, x.c2} + 34'd32768;
      wsum = {1'b0, HAMMING_BASE} + hp[33:16];
      case (x.kind) inside
        WIN_SHEPP, WIN_COSINE: wsel = {1'b0, x.cw};
        WIN_HAMMING:           wsel = wsum;
        WIN_HANN:              wsel = {1'b0, x.c2};
        default:               wsel = {1'b0, Q16_ONE};
      endcase
      if (wsel > {1'b0, Q16_ONE}) begin
        wsel = {1'b0, Q16_ONE};
      end
      wsel  = wsel + 18'd1;
      y.w15 = wsel[16:1];
      isum  = {2'b00, x.inv} + 34'd2;
      if (x.zero) begin
        y.mag = isum[33:2];
      end else if (x.odd) begin
        y.mag = {2'b00, x.qn};
      end else begin
        y.mag = '0;
      end
    end
    if (k == 39) begin
      fp  = {16'd0, x.mag} * {32'd0, x.w15} + 48'd16384;
      res = {1'b0, fp[46:15]};
      if (x.err) begin
        y.coef = '0;
      end else if (x.odd) begin
        if (res > 33'h080000000) begin
          y.coef = 32'h80000000;
        end else begin
          y.coef = ~res[31:0] + 32'd1;
        end
      end else if (res > 33'h07FFFFFFF) begin
        y.coef = 32'h7FFFFFFF;
      end else begin
        y.coef = res[31:0];
      end
    end
    return y;
  endfunction

  rktg_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg_ready (cfg_ready),
    .cfg       (cfg)
  );

  assign adv      = !(vld_r[NST-1] && out_stall);
  assign in_stall = !adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[NST-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      stg_r[0] <= entry(in_tap_position, cfg);
      for (int unsigned k = 1; k < NST; k++) begin
        stg_r[k] <= step(k, stg_r[k-1]);
      end
    end
  end

  assign out_valid          = vld_r[NST-1];
  assign out_coefficient    = $signed(stg_r[NST-1].coef);
  assign out_position_error = stg_r[NST-1].err;

endmodule

FILE: rtl/core/rktg_checker.sv
// Port-level checks for the ramp kernel tap generator, bound to the top level.
// Depends only on the ports of ramp_kernel_tap_generator_core.
module rktg_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [31:0] out_coefficient,
  input logic               out_position_error
);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result shown straight after reset");

  a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_position_error |-> out_coefficient == 32'sd0)
    else $error("out-of-range tap with nonzero coefficient");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_coefficient)
                               && $stable(out_position_error))
    else $error("stalled result changed");

  a_in_stall_cause: assert property (@(posedge clk) in_stall |-> out_valid && out_stall)
    else $error("request stalled without a blocked result");

endmodule

bind ramp_kernel_tap_generator_core rktg_checker u_rktg_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_stall           (in_stall),
  .out_valid          (out_valid),
  .out_stall          (out_stall),
  .out_coefficient    (out_coefficient),
  .out_position_error (out_position_error)
);

FILE: bench/ramp_kernel_tap_generator_core_test.sv
// Testbench for the ramp kernel tap generator core: directed and random tap positions.
// Expected coefficients come from a fixed-point window and kernel model held here.
// Depends on rktg_pkg and ramp_kernel_tap_generator_core.
`timescale 1ns / 1ps

module ramp_kernel_tap_generator_core_test;
  import rktg_pkg::*;

  typedef struct {
    logic [31:0] coefficient;
    logic        position_error;
  } tap_result_t;

  typedef struct {
    logic [11:0] tap;
    logic        known;
    logic [31:0] coefficient;
    logic        position_error;
  } tap_row_t;

  localparam int CYCLE_LIMIT = 2000000;
  localparam int PIPE_DEPTH  = 40;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  logic [11:0]       in_tap_position;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic signed [31:0] out_coefficient;
  logic              out_position_error;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [1:0]        cfg_index;
  logic [31:0]       cfg_data;

  logic [10:0] cur_radius;
  logic [2:0]  cur_window;
  logic [31:0] cur_inv_sq;

  tap_result_t pending_coefs[$];
  int  mismatches = 0;
  int  cycles = 0;
  int  send_idle_pct;
  int  recv_stall_pct;
  int  hold_cycles;
  bit  hold_request;

  ramp_kernel_tap_generator_core i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_tap_position(in_tap_position),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_coefficient(out_coefficient), .out_position_error(out_position_error),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic longint series_q16(longint z, bit sinc);
    longint acc;
    int     top;
    top = sinc ? 3 : 4;
    acc = sinc ? 7 : 2;
    for (int j = top - 1; j >= 0; j--) begin
      if (acc < 0) acc = 0;
      case (j)
        0: acc = (sinc ? 26951 : 80852) - ((acc * z + 32768) >>> 16);
        1: acc = (sinc ? 3325 : 16624) - ((acc * z + 32768) >>> 16);
        2: acc = (sinc ? 195 : 1367) - ((acc * z + 32768) >>> 16);
        default: acc = 60 - ((acc * z + 32768) >>> 16);
      endcase
    end
    if (acc < 0) acc = 0;
    acc = 65536 - ((acc * z + 32768) >>> 16);
    if (acc < 0) acc = 0;
    if (acc > 65536) acc = 65536;
    return acc;
  endfunction

  function automatic longint window_q15(longint offset);
    longint rm, phase, z, w, c;
    rm = (cur_radius == 0) ? 1 : cur_radius;
    phase = ((offset << 16) + rm / 2) / rm;
    if (phase > 65536) phase = 65536;
    z = (phase * phase + 32768) >> 16;
    case (cur_window)
      WIN_SHEPP:  w = series_q16(z, 1'b1);
      WIN_COSINE: w = series_q16(z, 1'b0);
      WIN_HAMMING: begin
        c = series_q16(z, 1'b0);
        c = (c * c + 32768) >> 16;
        w = 5243 + ((60293 * c + 32768) >> 16);
      end
      WIN_HANN: begin
        c = series_q16(z, 1'b0);
        w = (c * c + 32768) >> 16;
      end
      default: w = 65536;
    endcase
    if (w > 65536) w = 65536;
    return (w + 1) >> 1;
  endfunction

  function automatic tap_result_t kernel_tap(logic [11:0] tap);
    tap_result_t r;
    longint unsigned offset, mag, num, quo, res;
    bit negative;
    negative = 1'b0;
    if (longint'(tap) > 2 * longint'(cur_radius)) begin
      r.coefficient = '0;
      r.position_error = 1'b1;
      return r;
    end
    offset = (tap >= cur_radius) ? tap - cur_radius : cur_radius - tap;
    if (offset == 0) begin
      mag = (longint'(cur_inv_sq) + 2) >> 2;
    end else if (offset[0]) begin
      num = longint'(cur_inv_sq) * 64'd435171170;
      quo = num / (offset * offset);
      mag = (quo + 64'h8000_0000) >> 32;
      negative = 1'b1;
    end else begin
      mag = 0;
    end
    res = (mag * window_q15(offset) + 16384) >> 15;
    if (negative) begin
      if (res > 64'h8000_0000) res = 64'h8000_0000;
      r.coefficient = 32'(-res);
    end else begin
      if (res > 64'h7FFF_FFFF) res = 64'h7FFF_FFFF;
      r.coefficient = 32'(res);
    end
    r.position_error = 1'b0;
    return r;
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      hold_cycles <= 0;
      out_stall <= 1'b0;
    end else if (hold_request && hold_cycles == 0) begin
      hold_cycles <= 300;
      out_stall <= 1'b1;
    end else if (hold_cycles > 1) begin
      hold_cycles <= hold_cycles - 1;
      out_stall <= 1'b1;
    end else begin
      hold_cycles <= 0;
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    tap_result_t exp_r;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_coefs.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result %0d", out_coefficient);
      end else begin
        exp_r = pending_coefs.pop_front();
        if (exp_r.coefficient !== out_coefficient
            || exp_r.position_error !== out_position_error) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Mismatch: expected %0d/%0b, got %0d/%0b", $signed(exp_r.coefficient),
                     exp_r.position_error, out_coefficient, out_position_error);
        end
      end
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [31:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_RADIUS: cur_radius = (value[10:0] > MAX_RADIUS) ? 11'(MAX_RADIUS) : value[10:0];
      REG_WINDOW: cur_window = value[2:0];
      default:    cur_inv_sq = value;
    endcase
  endtask

  task automatic send_tap(logic [11:0] tap, logic known, tap_result_t typed);
    tap_result_t exp_r;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_tap_position <= tap;
    exp_r = known ? typed : kernel_tap(tap);
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_coefs.push_back(exp_r);
  endtask

  task automatic drain_all();
    in_valid <= 1'b0;
    while (pending_coefs.size() != 0) @(posedge clk);
    repeat (PIPE_DEPTH + 5) @(posedge clk);
  endtask

  task automatic random_phase(int count, int idle_pct, int stall_pct);
    int r;
    tap_result_t none;
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    none = '{default: '0};
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(99);
      if (r < 80) send_tap(12'($urandom_range(2 * cur_radius)), 1'b0, none);
      else if (r < 90) send_tap(12'($urandom_range(4095)), 1'b0, none);
      else send_tap(12'(cur_radius + $urandom_range(1) - (cur_radius != 0)), 1'b0, none);
    end
    drain_all();
  endtask

  tap_row_t directed_rows[$];
  tap_result_t typed_r;

  initial begin
    hold_request = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_tap_position = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_RADIUS;
    cfg_data = '0;
    cur_radius = 11'd255;
    cur_window = WIN_RAMLAK;
    cur_inv_sq = 32'd65536;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    directed_rows = '{
      '{12'd255, 1'b1, 32'd16384, 1'b0},
      '{12'd254, 1'b0, 32'd0, 1'b0},
      '{12'd253, 1'b1, 32'd0, 1'b0},
      '{12'd0, 1'b0, 32'd0, 1'b0},
      '{12'd510, 1'b0, 32'd0, 1'b0},
      '{12'd511, 1'b1, 32'd0, 1'b1},
      '{12'd4095, 1'b1, 32'd0, 1'b1},
      '{12'd2048, 1'b1, 32'd0, 1'b1}
    };
    foreach (directed_rows[n]) begin
      typed_r.coefficient = directed_rows[n].coefficient;
      typed_r.position_error = directed_rows[n].position_error;
      send_tap(directed_rows[n].tap, directed_rows[n].known, typed_r);
    end
    drain_all();

    for (int wk = 0; wk < 8; wk++) begin
      write_reg(REG_WINDOW, 32'(wk));
      for (int n = 0; n < 3; n++) begin
        typed_r = '{default: '0};
        send_tap(12'($urandom_range(510)), 1'b0, typed_r);
      end
      drain_all();
    end

    write_reg(REG_RADIUS, 32'd0);
    write_reg(REG_INVSQ, 32'hFFFF_FFFF);
    typed_r.coefficient = 32'h4000_0000;
    typed_r.position_error = 1'b0;
    send_tap(12'd0, 1'b1, typed_r);
    typed_r.coefficient = '0;
    typed_r.position_error = 1'b1;
    send_tap(12'd1, 1'b1, typed_r);
    drain_all();
    write_reg(REG_RADIUS, 32'd2047);
    write_reg(REG_INVSQ, 32'd0);
    send_tap(12'd1024, 1'b1, '{32'd0, 1'b0});
    send_tap(12'd2049, 1'b1, '{32'd0, 1'b1});
    drain_all();

    write_reg(REG_INVSQ, 32'hFFFF_FFFF);
    write_reg(REG_RADIUS, 32'd1);
    write_reg(REG_WINDOW, 32'(WIN_RAMLAK));
    random_phase(60, 0, 0);

    write_reg(REG_RADIUS, 32'd1024);
    write_reg(REG_WINDOW, 32'(WIN_HANN));
    write_reg(REG_INVSQ, 32'($urandom()));
    random_phase(80, 85, 0);

    write_reg(REG_RADIUS, 32'($urandom_range(2, 40)));
    write_reg(REG_WINDOW, 32'(WIN_SHEPP));
    write_reg(REG_INVSQ, 32'($urandom()) | 32'd1);
    random_phase(80, 0, 85);

    write_reg(REG_RADIUS, 32'($urandom_range(1, 300)));
    write_reg(REG_WINDOW, 32'(WIN_HAMMING));
    write_reg(REG_INVSQ, 32'd1);
    random_phase(80, 28, 28);

    write_reg(REG_RADIUS, 32'($urandom_range(1, 1024)));
    write_reg(REG_WINDOW, 32'(WIN_COSINE));
    write_reg(REG_INVSQ, 32'($urandom()));
    hold_request <= 1'b1;
    @(posedge clk);
    hold_request <= 1'b0;
    random_phase(100, 0, 0);

    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/core/rktg_pkg.sv
rtl/core/rktg_cfg.sv
rtl/core/ramp_kernel_tap_generator_core.sv
rtl/core/rktg_checker.sv
bench/ramp_kernel_tap_generator_core_test.sv
